@@ rtl/core/dmix_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dmix_pkg
// Types, codes and shared helpers for the differential drive mixer.
// ----------------------------------------------------------------------------
package dmix_pkg;

  typedef enum logic [1:0] {
    MODE_TANK   = 2'd0,
    MODE_ARCADE = 2'd1,
    MODE_QUICK  = 2'd2
  } drive_mode_t;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_THRUST_DB = 2'd0;
  localparam logic [1:0] REG_ROTATE_DB = 2'd1;
  localparam logic [1:0] REG_QT_SENS   = 2'd2;

  localparam logic [14:0] THRUST_DB_RST = 15'd3277;
  localparam logic [14:0] ROTATE_DB_RST = 15'd1966;
  localparam logic [14:0] QT_SENS_RST   = 15'd0;

  localparam logic signed [17:0] Q_MAX = 18'sd32767;
  localparam logic signed [17:0] Q_MIN = -18'sd32767;

  typedef struct packed {
    logic signed [15:0] left_stick_y;
    logic signed [15:0] left_stick_z;
    logic signed [15:0] right_stick_y;
    logic signed [15:0] right_stick_x;
    logic signed [15:0] right_stick_z;
    logic               want_quick_turn;
    logic               want_arcade;
    logic               want_reverse;
    logic               want_high_gear;
  } dmix_in_t;

  typedef struct packed {
    logic signed [15:0] left_drive;
    logic signed [15:0] right_drive;
    logic               high_gear;
    drive_mode_t        drive_mode;
  } dmix_out_t;

  typedef struct packed {
    logic [14:0] thrust_deadband;
    logic [14:0] rotate_deadband;
    logic [14:0] quick_turn_sensitivity;
  } dmix_cfg_t;

  // per-word control that rides alongside the cubic units
  typedef struct packed {
    drive_mode_t        mode;
    logic               high_gear;
    logic [14:0]        abs_thrust;
    logic signed [15:0] tank_left;
    logic signed [15:0] tank_right;
  } dmix_side_t;

  function automatic logic signed [15:0] sat_q(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > Q_MAX) begin
      r = 16'sd32767;
    end else if (v < Q_MIN) begin
      r = -16'sd32767;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/dmix_cfg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dmix_cfg
// APB register file: deadbands and quick-turn sensitivity.
// ----------------------------------------------------------------------------
module dmix_cfg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output dmix_pkg::dmix_cfg_t cfg_o
);
  import dmix_pkg::*;

  dmix_cfg_t cfg_r;
  dmix_cfg_t cfg_nxt;
  logic      wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (paddr[3:2])
        REG_THRUST_DB: cfg_nxt.thrust_deadband        = pwdata[14:0];
        REG_ROTATE_DB: cfg_nxt.rotate_deadband        = pwdata[14:0];
        REG_QT_SENS:   cfg_nxt.quick_turn_sensitivity = pwdata[14:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_THRUST_DB: prdata = {17'd0, cfg_r.thrust_deadband};
      REG_ROTATE_DB: prdata = {17'd0, cfg_r.rotate_deadband};
      REG_QT_SENS:   prdata = {17'd0, cfg_r.quick_turn_sensitivity};
      default:       prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.thrust_deadband        <= THRUST_DB_RST;
      cfg_r.rotate_deadband        <= ROTATE_DB_RST;
      cfg_r.quick_turn_sensitivity <= QT_SENS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule
`default_nettype wire

@@ rtl/core/dmix_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dmix_front
// Input stage: mode select, negation, deadbands, sensitivity mapping.
// ----------------------------------------------------------------------------
module dmix_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                valid_i,
  input  dmix_pkg::dmix_in_t  data_i,
  input  dmix_pkg::dmix_cfg_t cfg_i,
  output logic                valid_o,
  output logic signed [15:0]  v0_o,
  output logic [14:0]         a0_o,
  output logic signed [15:0]  v1_o,
  output logic [14:0]         a1_o,
  output dmix_pkg::dmix_side_t side_o
);
  import dmix_pkg::*;

  logic               valid_r;
  logic signed [15:0] v0_r, v0_nxt, v1_r, v1_nxt;
  logic [14:0]        a0_r, a0_nxt, a1_r, a1_nxt;
  dmix_side_t         side_r, side_nxt;

  logic signed [17:0] ly_x, ry_x;
  logic signed [15:0] thrust, tank_ry;
  logic [15:0]        abs_t16, abs_rx;
  logic               t_pass, r_pass;
  logic signed [15:0] t_dead, r_dead;
  logic [14:0]        sens_lz, sens_rz;

  always_comb begin
    ly_x    = {{2{data_i.left_stick_y[15]}}, data_i.left_stick_y};
    ry_x    = {{2{data_i.right_stick_y[15]}}, data_i.right_stick_y};
    thrust  = sat_q(data_i.want_reverse ? ly_x : -ly_x);
    tank_ry = sat_q(data_i.want_reverse ? ry_x : -ry_x);
    // thrust is never -32768 after saturation, so 15 bits hold its magnitude
    abs_t16 = thrust[15] ? 16'(-thrust) : 16'(thrust);
    abs_rx  = data_i.right_stick_x[15] ? 16'(-data_i.right_stick_x)
                                       : 16'(data_i.right_stick_x);
    t_pass  = abs_t16[14:0] >= cfg_i.thrust_deadband;
    r_pass  = abs_rx >= {1'b0, cfg_i.rotate_deadband};
    t_dead  = t_pass ? thrust : 16'sd0;
    r_dead  = r_pass ? data_i.right_stick_x : 16'sd0;
    // (z + 1) / 2 mapped to Q0.15
    sens_lz = {~data_i.left_stick_z[15], data_i.left_stick_z[14:1]};
    sens_rz = {~data_i.right_stick_z[15], data_i.right_stick_z[14:1]};

    if (data_i.want_quick_turn) begin
      v0_nxt = data_i.right_stick_x;
      a0_nxt = cfg_i.quick_turn_sensitivity;
      side_nxt.mode = MODE_QUICK;
    end else begin
      v0_nxt = t_dead;
      a0_nxt = sens_lz;
      side_nxt.mode = data_i.want_arcade ? MODE_ARCADE : MODE_TANK;
    end
    v1_nxt              = r_dead;
    a1_nxt              = sens_rz;
    side_nxt.high_gear  = data_i.want_high_gear;
    side_nxt.abs_thrust = t_pass ? abs_t16[14:0] : 15'd0;
    side_nxt.tank_left  = thrust;
    side_nxt.tank_right = tank_ry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    v0_r   <= v0_nxt;
    a0_r   <= a0_nxt;
    v1_r   <= v1_nxt;
    a1_r   <= a1_nxt;
    side_r <= side_nxt;
  end

  assign valid_o = valid_r;
  assign v0_o    = v0_r;
  assign a0_o    = a0_r;
  assign v1_o    = v1_r;
  assign a1_o    = a1_r;
  assign side_o  = side_r;

endmodule
`default_nettype wire

@@ rtl/core/dmix_cubic.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dmix_cubic
// Three-stage cubic shaper: c = a*v^3 + (1-a)*v, rounded half away from zero.
// ----------------------------------------------------------------------------
module dmix_cubic (
  input  logic               clk,
  input  logic signed [15:0] v_i,
  input  logic [14:0]        a_i,
  output logic signed [16:0] c_o
);
  import dmix_pkg::*;

  localparam logic signed [62:0] ROUND_HALF = 63'sd1 <<< 44;

  logic signed [31:0] sq_r, sq_nxt;
  logic signed [30:0] av_r, av_nxt;
  logic signed [31:0] lin_r, lin_nxt;
  logic signed [16:0] wgt;
  logic signed [62:0] acc_r, acc_nxt;
  logic signed [62:0] rnd;
  logic signed [16:0] c_r, c_nxt;

  // stage 1: v^2, a*v, (1-a)*v
  always_comb begin
    wgt     = 17'sd32768 - $signed({2'b00, a_i});
    sq_nxt  = v_i * v_i;
    av_nxt  = $signed({1'b0, a_i}) * v_i;
    lin_nxt = wgt * v_i;
  end

  // stage 2: a*v^3 in Q60 plus linear term lifted to Q60
  always_comb begin
    acc_nxt = (av_r * sq_r) + (63'(lin_r) <<< 30);
  end

  // stage 3: drop 45 fraction bits; negative values get one less bias
  always_comb begin
    rnd   = acc_r + ROUND_HALF - $signed({62'd0, acc_r[62]});
    c_nxt = rnd[61:45];
  end

  always_ff @(posedge clk) begin
    sq_r  <= sq_nxt;
    av_r  <= av_nxt;
    lin_r <= lin_nxt;
    acc_r <= acc_nxt;
    c_r   <= c_nxt;
  end

  assign c_o = c_r;

endmodule
`default_nettype wire

@@ rtl/core/dmix_mixer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dmix_mixer
// Arcade: rotation scaled by thrust magnitude, sum/difference, saturation.
// ----------------------------------------------------------------------------
module dmix_mixer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 valid_i,
  input  logic signed [16:0]   c0_i,
  input  logic signed [16:0]   c1_i,
  input  dmix_pkg::dmix_side_t side_i,
  output logic                 valid_o,
  output dmix_pkg::dmix_out_t  data_o
);
  import dmix_pkg::*;

  localparam logic signed [32:0] ROUND_HALF = 33'sd16384;

  logic               valid_e_r, valid_f_r;
  logic signed [32:0] prod_r, prod_nxt;
  logic signed [16:0] c0_e_r;
  dmix_side_t         side_e_r;
  logic signed [32:0] rnd;
  logic signed [16:0] rot;
  logic signed [17:0] c0_x, rot_x;
  dmix_out_t          out_r, out_nxt;

  assign prod_nxt = c1_i * $signed({1'b0, side_i.abs_thrust});

  always_comb begin
    rnd   = prod_r + ROUND_HALF - $signed({32'd0, prod_r[32]});
    rot   = rnd[31:15];
    c0_x  = {c0_e_r[16], c0_e_r};
    rot_x = {rot[16], rot};
    out_nxt.high_gear  = side_e_r.high_gear;
    out_nxt.drive_mode = side_e_r.mode;
    case (side_e_r.mode)
      MODE_QUICK: begin
        out_nxt.left_drive  = sat_q(c0_x);
        out_nxt.right_drive = sat_q(-c0_x);
      end
      MODE_ARCADE: begin
        out_nxt.left_drive  = sat_q(c0_x + rot_x);
        out_nxt.right_drive = sat_q(c0_x - rot_x);
      end
      default: begin
        out_nxt.left_drive  = side_e_r.tank_left;
        out_nxt.right_drive = side_e_r.tank_right;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_e_r <= 1'b0;
      valid_f_r <= 1'b0;
    end else begin
      valid_e_r <= valid_i;
      valid_f_r <= valid_e_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r   <= prod_nxt;
    c0_e_r   <= c0_i;
    side_e_r <= side_i;
    out_r    <= out_nxt;
  end

  assign valid_o = valid_f_r;
  assign data_o  = out_r;

endmodule
`default_nettype wire

@@ rtl/core/differential_drive_mixer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// differential_drive_mixer
// Joystick to left/right wheel command mixer (tank, arcade, quick turn).
// ----------------------------------------------------------------------------
// Takes one word per clock: busy is high only while rst_n is low, so every
// start outside reset is accepted.
// Each result appears on out_data with out_valid high for one cycle; it passes
// through the input stage, the three-stage cubic shapers and the two-stage
// rotation scale and output saturation. Results come back in order and cannot
// be held off.
// ----------------------------------------------------------------------------
module differential_drive_mixer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  dmix_pkg::dmix_in_t  in_data,
  output logic                out_valid,
  output dmix_pkg::dmix_out_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import dmix_pkg::*;

  localparam int CUBIC_LAT = 3;

  dmix_cfg_t          cfg;
  logic               fr_valid;
  logic signed [15:0] fr_v0, fr_v1;
  logic [14:0]        fr_a0, fr_a1;
  dmix_side_t         fr_side;
  logic signed [16:0] c0, c1;

  logic [CUBIC_LAT-1:0] valid_dly_r;
  dmix_side_t           side_dly_r [CUBIC_LAT];

  // the input stage clears its valid bit in reset, so refuse words there
  assign busy = ~rst_n;

  dmix_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dmix_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (start),
    .data_i  (in_data),
    .cfg_i   (cfg),
    .valid_o (fr_valid),
    .v0_o    (fr_v0),
    .a0_o    (fr_a0),
    .v1_o    (fr_v1),
    .a1_o    (fr_a1),
    .side_o  (fr_side)
  );

  // unit 0: thrust or quick-turn; unit 1: arcade rotation
  dmix_cubic u_cubic0 (
    .clk (clk),
    .v_i (fr_v0),
    .a_i (fr_a0),
    .c_o (c0)
  );

  dmix_cubic u_cubic1 (
    .clk (clk),
    .v_i (fr_v1),
    .a_i (fr_a1),
    .c_o (c1)
  );

  // control rides next to the cubic units
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_dly_r <= '0;
    end else begin
      valid_dly_r <= {valid_dly_r[CUBIC_LAT-2:0], fr_valid};
    end
  end

  always_ff @(posedge clk) begin
    side_dly_r[0] <= fr_side;
    for (int i = 1; i < CUBIC_LAT; i++) begin
      side_dly_r[i] <= side_dly_r[i-1];
    end
  end

  dmix_mixer u_mixer (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (valid_dly_r[CUBIC_LAT-1]),
    .c0_i    (c0),
    .c1_i    (c1),
    .side_i  (side_dly_r[CUBIC_LAT-1]),
    .valid_o (out_valid),
    .data_o  (out_data)
  );

endmodule
`default_nettype wire

@@ dv/differential_drive_mixer_tb.sv @@
// ----------------------------------------------------------------------------
// differential_drive_mixer_tb
// Self-checking bench for the drive mixer: a directed table, then phases of
// random joystick words under different deadband and quick-turn settings.
// Every word accepted gets an expected result, typed in or from a local model,
// and each result strobe is compared against the oldest expected result.
// ----------------------------------------------------------------------------
module differential_drive_mixer_tb;
  import dmix_pkg::*;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  dmix_in_t    in_data = '0;
  logic        out_valid;
  dmix_out_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  differential_drive_mixer DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  typedef struct packed {
    dmix_in_t  word;
    logic      typed;
    dmix_out_t want;
  } drive_row_t;

  // local copy of the register file
  logic [14:0] db_thrust = THRUST_DB_RST;
  logic [14:0] db_rotate = ROTATE_DB_RST;
  logic [14:0] qt_gain   = QT_SENS_RST;

  dmix_out_t drive_expected[$];
  int        fail_count = 0;
  int        burst_left = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("differential_drive_mixer_tb: done, errors");
    $finish;
  end

  function automatic longint mag(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint clamp_q(input longint v);
    if (v > 32767) return 32767;
    if (v < -32767) return -32767;
    return v;
  endfunction

  // divide by 2^k, half away from zero
  function automatic longint round_half_away(input longint x, input int k);
    longint m;
    longint r;
    m = mag(x);
    r = (m + (longint'(1) << (k - 1))) >> k;
    return (x < 0) ? -r : r;
  endfunction

  // a*v^3 + (1-a)*v in Q60, back to Q1.15
  function automatic longint cubic_shape(input longint v, input longint a);
    longint acc;
    acc = a * (v * v * v) + (32768 - a) * v * (longint'(1) << 30);
    return round_half_away(acc, 45);
  endfunction

  function automatic dmix_out_t predict_drive(input dmix_in_t w);
    dmix_out_t o;
    longint ly, lz, ry, rx, rz, t, r, lft, rgt;
    ly = $signed(w.left_stick_y);
    lz = $signed(w.left_stick_z);
    ry = $signed(w.right_stick_y);
    rx = $signed(w.right_stick_x);
    rz = $signed(w.right_stick_z);
    if (w.want_quick_turn) begin
      lft = cubic_shape(rx, longint'(qt_gain));
      rgt = -lft;
      o.drive_mode = MODE_QUICK;
    end else if (w.want_arcade) begin
      t = clamp_q(w.want_reverse ? ly : -ly);
      if (mag(t) < longint'(db_thrust)) t = 0;
      r = (mag(rx) < longint'(db_rotate)) ? 0 : rx;
      r = cubic_shape(r, (rz + 32768) / 2);
      r = round_half_away(r * mag(t), 15);
      t = cubic_shape(t, (lz + 32768) / 2);
      lft = t + r;
      rgt = t - r;
      o.drive_mode = MODE_ARCADE;
    end else begin
      lft = w.want_reverse ? ly : -ly;
      rgt = w.want_reverse ? ry : -ry;
      o.drive_mode = MODE_TANK;
    end
    o.left_drive  = 16'(clamp_q(lft));
    o.right_drive = 16'(clamp_q(rgt));
    o.high_gear   = w.want_high_gear;
    return o;
  endfunction

  function automatic dmix_in_t mk_in(input int ly, input int lz, input int ry,
                                     input int rx, input int rz, input logic q,
                                     input logic a, input logic rv, input logic g);
    dmix_in_t w;
    w.left_stick_y    = 16'(ly);
    w.left_stick_z    = 16'(lz);
    w.right_stick_y   = 16'(ry);
    w.right_stick_x   = 16'(rx);
    w.right_stick_z   = 16'(rz);
    w.want_quick_turn = q;
    w.want_arcade     = a;
    w.want_reverse    = rv;
    w.want_high_gear  = g;
    return w;
  endfunction

  function automatic dmix_out_t mk_out(input int l, input int r, input logic g,
                                       input drive_mode_t m);
    dmix_out_t o;
    o.left_drive  = 16'(l);
    o.right_drive = 16'(r);
    o.high_gear   = g;
    o.drive_mode  = m;
    return o;
  endfunction

  // stick value biased to the extremes and the deadband edges
  function automatic logic signed [15:0] pick_axis();
    logic signed [15:0] v;
    int m;
    m = 0;
    case ($urandom_range(0, 11))
      0: return 16'h8000;
      1: return 16'h8001;
      2: return 16'h7fff;
      3: return 16'h0000;
      4: m = int'($urandom_range(0, 4000));
      5: m = int'(db_thrust) + int'($urandom_range(0, 4)) - 2;
      6: m = int'(db_rotate) + int'($urandom_range(0, 4)) - 2;
      default: return 16'($urandom);
    endcase
    if (m < 0) m = 0;
    if (m > 32767) m = 32767;
    v = 16'(m);
    if ($urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  function automatic dmix_in_t rand_word();
    return mk_in(int'(pick_axis()), int'(pick_axis()), int'(pick_axis()),
                 int'(pick_axis()), int'(pick_axis()),
                 $urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  // bursts of back-to-back words with random gaps between them
  task automatic issue_word(input dmix_in_t w, input logic typed, input dmix_out_t want);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start   <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (busy !== 1'b0);
    drive_expected.push_back(typed ? want : predict_drive(w));
  endtask

  // setup then access; psel is left high so writes can run back to back
  task automatic cfg_write(input logic [1:0] idx, input logic [14:0] val);
    logic [31:0] d;
    d = $urandom;
    d[14:0] = val;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= d;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    case (idx)
      REG_THRUST_DB: db_thrust = val;
      REG_ROTATE_DB: db_rotate = val;
      REG_QT_SENS:   qt_gain   = val;
      default: ;
    endcase
  endtask

  task automatic wait_drain();
    while (drive_expected.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    dmix_out_t want;
    if (rst_n && out_valid) begin
      if (drive_expected.size() == 0) begin
        note_failure($sformatf("unexpected result word: l=%0d r=%0d g=%0d m=%0d",
                     out_data.left_drive, out_data.right_drive, out_data.high_gear,
                     out_data.drive_mode));
      end else begin
        want = drive_expected.pop_front();
        if (out_data.left_drive !== want.left_drive ||
            out_data.right_drive !== want.right_drive ||
            out_data.high_gear !== want.high_gear ||
            out_data.drive_mode !== want.drive_mode) begin
          note_failure($sformatf(
            "mismatch: expected l=%0d r=%0d g=%0d m=%0d, got l=%0d r=%0d g=%0d m=%0d",
            want.left_drive, want.right_drive, want.high_gear, want.drive_mode,
            out_data.left_drive, out_data.right_drive, out_data.high_gear,
            out_data.drive_mode));
        end
      end
    end
  end

  initial begin
    drive_row_t rows[$];
    int phase_cfg[8][3];
    dmix_out_t none;
    none = '0;

    // typed rows assume the reset register values
    rows.push_back('{mk_in(-32768, 0, 32767, 0, 0, 0, 0, 0, 1), 1,
                     mk_out(32767, -32767, 1, MODE_TANK)});
    rows.push_back('{mk_in(-32768, 0, 32767, 0, 0, 0, 0, 1, 0), 1,
                     mk_out(-32767, 32767, 0, MODE_TANK)});
    rows.push_back('{mk_in(1000, 5, -2000, 7, 9, 0, 0, 0, 1), 1,
                     mk_out(-1000, 2000, 1, MODE_TANK)});
    rows.push_back('{mk_in(0, 0, -32768, 0, 0, 0, 0, 0, 0), 1,
                     mk_out(0, 32767, 0, MODE_TANK)});
    rows.push_back('{mk_in(12, -1, -34, 0, 0, 0, 0, 1, 0), 1,
                     mk_out(12, -34, 0, MODE_TANK)});
    // quick turn wins over arcade; zero gain leaves the stick linear
    rows.push_back('{mk_in(100, 0, 0, 12345, 0, 1, 1, 1, 1), 1,
                     mk_out(12345, -12345, 1, MODE_QUICK)});
    rows.push_back('{mk_in(0, 0, 0, -32768, 0, 1, 0, 0, 0), 1,
                     mk_out(-32767, 32767, 0, MODE_QUICK)});
    rows.push_back('{mk_in(0, 0, 0, 32767, 0, 1, 0, 0, 1), 1,
                     mk_out(32767, -32767, 1, MODE_QUICK)});
    rows.push_back('{mk_in(0, 0, 0, 0, 0, 1, 0, 0, 0), 1,
                     mk_out(0, 0, 0, MODE_QUICK)});
    // arcade with thrust inside its deadband, so rotation is scaled to zero
    rows.push_back('{mk_in(1000, 0, 0, 1000, 0, 0, 1, 0, 0), 1,
                     mk_out(0, 0, 0, MODE_ARCADE)});
    rows.push_back('{mk_in(-3276, 0, 0, 20000, 0, 0, 1, 0, 1), 1,
                     mk_out(0, 0, 1, MODE_ARCADE)});
    rows.push_back('{mk_in(0, 0, 0, 0, 0, 0, 1, 0, 0), 1,
                     mk_out(0, 0, 0, MODE_ARCADE)});
    // deadband edges, extremes and saturation, from the model
    rows.push_back('{mk_in(-3277, 0, 0, 0, 0, 0, 1, 0, 0), 0, none});
    rows.push_back('{mk_in(-20000, 100, 0, 1966, -100, 0, 1, 0, 0), 0, none});
    rows.push_back('{mk_in(-20000, 100, 0, -1965, -100, 0, 1, 0, 1), 0, none});
    rows.push_back('{mk_in(32767, 32767, 0, 32767, 32767, 0, 1, 0, 0), 0, none});
    rows.push_back('{mk_in(-32768, -32768, 5, -32768, -32768, 0, 1, 0, 1), 0, none});
    rows.push_back('{mk_in(-32768, 0, 0, 20000, 0, 0, 1, 1, 0), 0, none});
    rows.push_back('{mk_in(-32767, 0, 0, 32767, 0, 0, 1, 0, 1), 0, none});
    rows.push_back('{mk_in(-32767, 32767, 0, -32767, 32767, 0, 1, 1, 0), 0, none});
    rows.push_back('{mk_in(-16384, -16384, 0, 16384, 16384, 0, 1, 0, 1), 0, none});

    phase_cfg = '{'{0, 0, 0}, '{32767, 32767, 32767}, '{3277, 1966, 16384},
                  '{0, 32767, 1}, '{32767, 0, 32767}, '{-1, -1, -1},
                  '{-1, -1, -1}, '{-1, -1, -1}};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) issue_word(rows[i].word, rows[i].typed, rows[i].want);
    start <= 1'b0;

    for (int p = 0; p < 8; p++) begin
      wait_drain();
      for (int k = 0; k < 3; k++) begin
        // -1 marks a random setting
        cfg_write(k[1:0], 15'((phase_cfg[p][k] < 0) ? $urandom_range(0, 32767)
                                                    : phase_cfg[p][k]));
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      repeat (220) issue_word(rand_word(), 1'b0, none);
      start <= 1'b0;
    end

    wait_drain();
    repeat (12) @(posedge clk);
    if (fail_count == 0 && drive_expected.size() == 0) begin
      $display("differential_drive_mixer_tb: done, clean");
    end else begin
      $display("differential_drive_mixer_tb: done, errors");
    end
    $finish;
  end

endmodule
